@@ sv/isqs_pkg.sv @@
// ============================================================================
// isqs_pkg
// Shared types, field widths and command codes of the indexed sequence store.
// ============================================================================
package isqs_pkg;

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 9;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4,
        OP_LENGTH = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_BAD_INDEX = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // What every cell of the chain does on a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } entry_t;

    // Number of registered radix-8 levels needed to reduce n cells to one; n above 4096 is not covered.
    function automatic int read_levels(input int n);
        int levels;
        levels = 4;
        if (n <= 8)
        begin
            levels = 1;
        end
        else if (n <= 64)
        begin
            levels = 2;
        end
        else if (n <= 512)
        begin
            levels = 3;
        end
        return levels;
    endfunction

endpackage

@@ sv/isqs_cmd_if.sv @@
// ============================================================================
// isqs_cmd_if
// Command request channel: valid/ready handshake and the command fields.
// ============================================================================
interface isqs_cmd_if
    import isqs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [POSITION_W-1:0] position;
    logic [WORD_W-1:0]     x_word;
    logic [WORD_W-1:0]     y_word;
    logic [WORD_W-1:0]     z_word;

    modport source (output valid, opcode, position, x_word, y_word, z_word, input ready);
    modport sink   (input valid, opcode, position, x_word, y_word, z_word, output ready);
endinterface

@@ sv/isqs_rsp_if.sv @@
// ============================================================================
// isqs_rsp_if
// Result response channel: valid/ready handshake and the result fields.
// ============================================================================
interface isqs_rsp_if
    import isqs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_x;
    logic [WORD_W-1:0]   read_y;
    logic [WORD_W-1:0]   read_z;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, read_x, read_y, read_z, entry_count, input ready);
    modport sink   (input valid, status, read_x, read_y, read_z, entry_count, output ready);
endinterface

@@ sv/isqs_cell.sv @@
// ============================================================================
// isqs_cell
// One storage cell of the chain: holds the entry at a fixed position and
// takes a new entry or a neighbor's entry on the broadcast operation.
// ============================================================================
module isqs_cell
    import isqs_pkg::*;
#(
    parameter int CNT_W = 10,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [CNT_W-1:0] target,
    input  entry_t           fresh,
    input  entry_t           below,
    input  entry_t           above,
    output entry_t           data
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            CELL_LOAD:
            begin
                if (MY_INDEX == target)
                begin
                    entry_next = fresh;
                end
            end
            CELL_INSERT:
            begin
                if (MY_INDEX == target)
                begin
                    entry_next = fresh;
                end
                else if (MY_INDEX > target)
                begin
                    entry_next = below;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_INDEX >= target)
                begin
                    entry_next = above;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

@@ sv/isqs_read_tree.sv @@
// ============================================================================
// isqs_read_tree
// Read port of the cell chain: selects the addressed cell and reduces all
// cells through registered radix-8 OR levels to one entry.
// ============================================================================
module isqs_read_tree
    import isqs_pkg::*;
#(
    parameter  int N     = 512,
    localparam int IDX_W = $clog2(N)
)
(
    input  logic             clk,
    input  logic [IDX_W-1:0] pos,
    input  entry_t           cells [N],
    output entry_t           result
);

    localparam int LEVELS = read_levels(N);
    localparam int LEAVES = 8 ** LEVELS;

    entry_t leaf [LEAVES];
    entry_t node_reg [1:LEVELS][LEAVES];

    // Only the addressed cell drives its data into the tree.
    always_comb
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            leaf[j] = '0;
            if (j < N)
            begin
                if (pos == IDX_W'(j))
                begin
                    leaf[j] = cells[j];
                end
            end
        end
    end

    for (genvar k = 1; k <= LEVELS; k++)
    begin : g_level
        for (genvar j = 0; j < LEAVES; j++)
        begin : g_node
            if (j < (LEAVES >> (3 * k)))
            begin : g_live
                if (k == 1)
                begin : g_first
                    always_ff @(posedge clk)
                    begin
                        node_reg[k][j] <= leaf[8*j]   | leaf[8*j+1] | leaf[8*j+2]
                                        | leaf[8*j+3] | leaf[8*j+4] | leaf[8*j+5]
                                        | leaf[8*j+6] | leaf[8*j+7];
                    end
                end
                else
                begin : g_upper
                    always_ff @(posedge clk)
                    begin
                        node_reg[k][j] <= node_reg[k-1][8*j]   | node_reg[k-1][8*j+1]
                                        | node_reg[k-1][8*j+2] | node_reg[k-1][8*j+3]
                                        | node_reg[k-1][8*j+4] | node_reg[k-1][8*j+5]
                                        | node_reg[k-1][8*j+6] | node_reg[k-1][8*j+7];
                    end
                end
            end
            else
            begin : g_spare
                always_ff @(posedge clk)
                begin
                    node_reg[k][j] <= '0;
                end
            end
        end
    end

    assign result = node_reg[LEVELS][0];

endmodule

@@ sv/indexed_sequence_store.sv @@
// Timing: a command posts its result in the cycle after acceptance, except a
// successful get, which loads the position into get_pos_reg, passes through
// each registered radix-8 level of the read tree over the cells, and then
// posts the entry. Throughput: one command per cycle while the result
// register is free; a successful get holds off the next one until its entry
// is posted. Reset (rst_n low, asynchronous) empties the store.
// ============================================================================
// indexed_sequence_store
// Ordered store of three-word entries held in a chain of cells; entries are
// appended, inserted, removed, read and overwritten by position.
// ============================================================================
module indexed_sequence_store
    import isqs_pkg::*;
#(
    parameter int CAPACITY = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    isqs_cmd_if.sink   cmd,
    isqs_rsp_if.source rsp
);

    // Position indexes a cell; the count must also hold CAPACITY itself.
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // Common width for comparing the 9-bit request position with the count.
    localparam int CMP_W  = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    // Width from which the reported count is taken; it wraps above 1023.
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int LEVELS = read_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [WAIT_W-1:0]   wait_reg;
    logic [IDX_W-1:0]    get_pos_reg;
    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    entry_t              rsp_entry_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    logic                accept;
    logic                rsp_free;
    logic                rsp_load;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic                in_range;
    logic                full;
    status_t             status_now;
    cell_op_t            op_now;
    cell_op_t            cell_op;
    logic                is_get;
    logic                is_append;
    logic [CNT_W-1:0]    fill_next;
    logic [WIDE_W-1:0]   fill_next_wide;
    logic [WIDE_W-1:0]   fill_wide;
    logic [CNT_W-1:0]    target;
    entry_t              fresh;
    entry_t              cell_data [CAPACITY];
    entry_t              tree_out;

    // The result register is free when it is empty or being drained now.
    assign rsp_free   = !rsp_valid_reg || rsp.ready;
    assign cmd.ready  = (state_reg == ST_IDLE) && rsp_free;
    assign accept     = cmd.valid && cmd.ready;

    // A new result is posted in this cycle; it takes the place of a drained one.
    assign rsp_load   = (accept && !is_get)
                      || ((state_reg == ST_READ) && (wait_reg == '0) && rsp_free);

    assign pos_ext    = CMP_W'(cmd.position);
    assign fill_ext   = CMP_W'(fill_reg);
    assign in_range   = pos_ext < fill_ext;
    assign full       = fill_reg == CNT_W'(CAPACITY);
    assign fresh      = '{x: cmd.x_word, y: cmd.y_word, z: cmd.z_word};

    // Decode the command against the current count. Only accepted commands
    // that pass their checks reach the cells; rejected ones change nothing.
    always_comb
    begin
        status_now = STATUS_DONE;
        op_now     = CELL_HOLD;
        fill_next  = fill_reg;
        is_get     = 1'b0;
        is_append  = 1'b0;
        case (opcode_t'(cmd.opcode))
            OP_APPEND:
            begin
                if (full)
                begin
                    status_now = STATUS_FULL;
                end
                else
                begin
                    op_now    = CELL_LOAD;
                    is_append = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                // The full check wins over the index check.
                if (full)
                begin
                    status_now = STATUS_FULL;
                end
                else if (!in_range)
                begin
                    status_now = STATUS_BAD_INDEX;
                end
                else
                begin
                    op_now    = CELL_INSERT;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!in_range)
                begin
                    status_now = STATUS_BAD_INDEX;
                end
                else
                begin
                    op_now    = CELL_REMOVE;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            OP_GET:
            begin
                if (!in_range)
                begin
                    status_now = STATUS_BAD_INDEX;
                end
                else
                begin
                    is_get = 1'b1;
                end
            end
            OP_SET:
            begin
                if (!in_range)
                begin
                    status_now = STATUS_BAD_INDEX;
                end
                else
                begin
                    op_now = CELL_LOAD;
                end
            end
            default:
            begin
                // Length and the unused codes only report the count.
                status_now = STATUS_DONE;
            end
        endcase
    end

    assign cell_op        = accept ? op_now : CELL_HOLD;
    // A valid position is below the count, so it fits the count width.
    assign target         = is_append ? fill_reg : pos_ext[CNT_W-1:0];
    assign fill_next_wide = WIDE_W'(fill_next);
    assign fill_wide      = WIDE_W'(fill_reg);

    // The chain of cells. Every cell sees the same operation and target and
    // picks its new value from the request, its lower neighbor (insert moves
    // entries up) or its upper neighbor (remove moves entries down).
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t below;
        entry_t above;

        if (i == 0)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_below
            assign below = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_above
            assign above = cell_data[i+1];
        end

        isqs_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk    (clk),
            .op     (cell_op),
            .target (target),
            .fresh  (fresh),
            .below  (below),
            .above  (above),
            .data   (cell_data[i])
        );
    end

    // Reads go through a registered reduction over all cells. The position
    // is held in get_pos_reg for the whole walk so every level settles.
    isqs_read_tree #(
        .N (CAPACITY)
    ) u_read_tree (
        .clk    (clk),
        .pos    (get_pos_reg),
        .cells  (cell_data),
        .result (tree_out)
    );

    // Control and the result register. A get waits in ST_READ until the
    // tree output reflects get_pos_reg, then posts the entry once the result
    // register is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            wait_reg       <= '0;
            get_pos_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= STATUS_DONE;
            rsp_entry_reg  <= '0;
            rsp_count_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        fill_reg <= fill_next;
                        if (is_get)
                        begin
                            state_reg   <= ST_READ;
                            wait_reg    <= WAIT_W'(LEVELS);
                            get_pos_reg <= pos_ext[IDX_W-1:0];
                        end
                        else
                        begin
                            rsp_valid_reg  <= 1'b1;
                            rsp_status_reg <= status_now;
                            rsp_entry_reg  <= '0;
                            rsp_count_reg  <= fill_next_wide[COUNT_W-1:0];
                        end
                    end
                end
                ST_READ:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_reg <= wait_reg - WAIT_W'(1);
                    end
                    else if (rsp_free)
                    begin
                        state_reg      <= ST_IDLE;
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= STATUS_DONE;
                        rsp_entry_reg  <= tree_out;
                        rsp_count_reg  <= fill_wide[COUNT_W-1:0];
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.read_x      = rsp_entry_reg.x;
    assign rsp.read_y      = rsp_entry_reg.y;
    assign rsp.read_z      = rsp_entry_reg.z;
    assign rsp.entry_count = rsp_count_reg;

endmodule
